// ===== rtl/core/pms_pkg.sv =====
// Package for the pattern mask stream filter.
// Widths, register indexes, the mask byte and the cell control struct.
// No dependencies; every other file uses it by scoped names.
`timescale 1ns / 1ps

package pms_pkg;

  // window depth, also the longest pattern
  localparam int MAX_PATTERN = 8;
  localparam int POS_W       = $clog2(MAX_PATTERN);
  localparam int FILL_W      = $clog2(MAX_PATTERN + 1);

  localparam int BYTE_W      = 8;
  localparam int PAT_W       = MAX_PATTERN * BYTE_W;
  localparam int LEN_W       = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 64;

  localparam logic [BYTE_W-1:0] MASK_BYTE = 8'h2A;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd1;

  // control broadcast to every window cell
  typedef struct packed {
    logic              shift;  // front byte leaves, cells take their neighbor
    logic              mask;   // front match: masked span shifts in as '*'
    logic              wr;     // a new byte is written this cycle
    logic [POS_W-1:0]  wpos;   // cell that takes the new byte
    logic [BYTE_W-1:0] din;    // the new byte
    logic [FILL_W-1:0] len;    // effective pattern length
  } cell_ctl_t;

endpackage

// ===== rtl/core/pms_if.sv =====
// Stream interfaces of the pattern mask stream filter: input beats,
// output beats and the configuration write channel. Uses pms_pkg.
`timescale 1ns / 1ps

interface pms_in_if;
  logic                        valid;
  logic                        ready;
  logic [pms_pkg::BYTE_W-1:0]  data_byte;
  logic                        end_of_text;

  modport source (output valid, data_byte, end_of_text, input ready);
  modport sink   (input valid, data_byte, end_of_text, output ready);
endinterface

interface pms_out_if;
  logic                        valid;
  logic                        ready;
  logic [pms_pkg::BYTE_W-1:0]  out_byte;
  logic                        out_last;

  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

interface pms_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pms_pkg::CFG_IDX_W-1:0]   index;
  logic [pms_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/pms_cell.sv =====
// One window cell: holds one text byte, compares it with its pattern byte,
// and shifts toward the front. Uses pms_pkg.
`timescale 1ns / 1ps

module pms_cell (
  input  logic                       clk,
  input  pms_pkg::cell_ctl_t         ctl,
  input  logic [pms_pkg::POS_W-1:0]  idx,
  input  logic [pms_pkg::BYTE_W-1:0] pat_byte,
  input  logic [pms_pkg::BYTE_W-1:0] nbr,
  output logic [pms_pkg::BYTE_W-1:0] byte_q,
  output logic                       hit
);

  logic [pms_pkg::FILL_W-1:0] pos;
  logic                       wr_here;
  logic                       mask_here;

  assign pos = pms_pkg::FILL_W'(idx);

  // positions past the pattern always agree
  assign hit       = (pos >= ctl.len) || (byte_q == pat_byte);
  assign wr_here   = ctl.wr && (ctl.wpos == idx);
  // the byte moving in from the right was inside the matched span
  assign mask_here = ctl.mask && ((pos + pms_pkg::FILL_W'(1)) < ctl.len);

  // byte register
  always_ff @(posedge clk) begin
    if (wr_here) begin
      byte_q <= ctl.din;
    end else if (ctl.shift) begin
      byte_q <= mask_here ? pms_pkg::MASK_BYTE : nbr;
    end
  end

endmodule

// ===== rtl/core/pattern_mask_stream_filter.sv =====
// Top level of the pattern mask stream filter.
// Holds config registers, window control, the cell row and the output register.
// Depends on pms_pkg, pms_if.sv and pms_cell.
`timescale 1ns / 1ps

// Masks every occurrence of a configured pattern of up to eight bytes with '*'.
// Channels: data_in takes one text beat (data_byte, end_of_text) per handshake,
// data_out gives one masked beat (out_byte, out_last), cfg writes register 0
// (pattern bytes, first byte in bits 7:0) or register 1 (pattern length,
// values above eight act as eight, zero passes bytes through).
// Bytes wait in a row of eight cells until the pattern length of lookahead is
// held; the front cell then decides its match and leaves through the output
// register. A byte moves from its cell to the output register once the beat
// completing its lookahead is held. Throughput is one beat per cycle in and
// out while data_out is ready; the single output register port sets that
// figure. A beat with end_of_text drains the window, one byte per cycle while
// data_out is ready; data_in is not ready until the last byte (out_last) is out.
// When data_out stalls, the window keeps taking beats until its eight cells
// are full, then data_in drops ready.
// Reset (rst, synchronous) empties the window and clears both registers.
// Configuration writes are taken at any time but are meant for an idle block.
module pattern_mask_stream_filter (
  input  logic      clk,
  input  logic      rst,
  pms_in_if.sink    data_in,
  pms_out_if.source data_out,
  pms_cfg_if.sink   cfg
);

  localparam logic [pms_pkg::FILL_W-1:0] FULL =
    pms_pkg::FILL_W'(pms_pkg::MAX_PATTERN);

  // configuration registers
  logic [pms_pkg::PAT_W-1:0]   pattern;
  logic [pms_pkg::FILL_W-1:0]  len;

  // window control
  logic [pms_pkg::FILL_W-1:0]  fill;
  logic [pms_pkg::FILL_W-1:0]  fill_next;
  logic [pms_pkg::FILL_W-1:0]  fill_ae;
  logic [pms_pkg::FILL_W-1:0]  keep;
  logic                        armed;
  logic                        armed_next;
  logic                        flushing;
  logic                        flushing_next;
  logic                        emit_req;
  logic                        emit;
  logic                        out_free;
  logic                        accept;
  logic                        match;

  // output register
  logic                        out_valid;
  logic [pms_pkg::BYTE_W-1:0]  out_byte;
  logic                        out_last;

  pms_pkg::cell_ctl_t                             ctl;
  logic [pms_pkg::MAX_PATTERN-1:0]                hits;
  logic [pms_pkg::MAX_PATTERN-1:0][pms_pkg::BYTE_W-1:0] cell_bytes;

  // config write port
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= '0;
      len     <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pms_pkg::REG_PATTERN_BYTES: begin
          pattern <= cfg.data;
        end
        pms_pkg::REG_PATTERN_LENGTH: begin
          len <= (cfg.data[pms_pkg::LEN_W-1:0] > pms_pkg::LEN_W'(pms_pkg::MAX_PATTERN))
                 ? FULL : pms_pkg::FILL_W'(cfg.data[pms_pkg::LEN_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  // window control
  assign keep     = (len == '0) ? '0 : len - pms_pkg::FILL_W'(1);
  assign emit_req = (armed && (fill > keep)) || (flushing && (fill != '0));
  assign out_free = !out_valid || data_out.ready;
  assign emit     = emit_req && out_free;
  assign fill_ae  = fill - pms_pkg::FILL_W'(emit);

  assign data_in.ready = !flushing && (fill_ae != FULL);
  assign accept        = data_in.valid && data_in.ready;

  assign match = (len != '0) && (fill >= len) && (&hits);

  assign fill_next     = fill_ae + pms_pkg::FILL_W'(accept);
  assign armed_next    = accept || (armed && (fill_next > keep));
  assign flushing_next = (accept && data_in.end_of_text) ||
                         (flushing && (fill_next != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      armed    <= 1'b0;
      flushing <= 1'b0;
    end else begin
      fill     <= fill_next;
      armed    <= armed_next;
      flushing <= flushing_next;
    end
  end

  // cell row
  assign ctl.shift = emit;
  assign ctl.mask  = emit && match;
  assign ctl.wr    = accept;
  assign ctl.wpos  = fill_ae[pms_pkg::POS_W-1:0];
  assign ctl.din   = data_in.data_byte;
  assign ctl.len   = len;

  for (genvar i = 0; i < pms_pkg::MAX_PATTERN; i++) begin : g_cell
    logic [pms_pkg::BYTE_W-1:0] nbr;
    if (i == pms_pkg::MAX_PATTERN - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_bytes[i+1];
    end
    pms_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .idx      (pms_pkg::POS_W'(i)),
      .pat_byte (pattern[i*pms_pkg::BYTE_W +: pms_pkg::BYTE_W]),
      .nbr      (nbr),
      .byte_q   (cell_bytes[i]),
      .hit      (hits[i])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (data_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= match ? pms_pkg::MASK_BYTE : cell_bytes[0];
      out_last <= flushing && (fill == pms_pkg::FILL_W'(1));
    end
  end

  assign data_out.valid    = out_valid;
  assign data_out.out_byte = out_byte;
  assign data_out.out_last = out_last;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL)
    else $error("window fill above depth");

  a_no_take_in_flush: assert property (@(posedge clk) disable iff (rst)
    flushing |-> !data_in.ready)
    else $error("input taken while draining");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (emit && flushing && (fill == pms_pkg::FILL_W'(1))) |=> (fill == '0) && !flushing)
    else $error("final byte left window non-empty");

  a_match_masks: assert property (@(posedge clk) disable iff (rst)
    (emit && match) |=> (data_out.out_byte == pms_pkg::MASK_BYTE))
    else $error("matched front byte not masked");

  a_emit_needs_data: assert property (@(posedge clk) disable iff (rst)
    emit |-> (fill != '0))
    else $error("emit from empty window");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for pattern_mask_stream_filter: a table of directed beats, then random
// text streams, each output beat checked against its table row or the in-bench window model.
// Depends on pms_pkg, the interfaces in pms_if.sv and the RTL top level.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned SETTLE_CYC = 12;      // output latency plus a full flush
  localparam int unsigned CYC_LIMIT  = 300000;
  localparam int unsigned PHASE_BEATS = 52;

  typedef struct packed {
    logic [pms_pkg::BYTE_W-1:0] data;
    logic                       last;
  } masked_beat_t;

  typedef enum logic {ROW_TEXT, ROW_CFG} row_kind_t;

  // text rows: byte in val[7:0]; cfg rows: pattern in val, length in len
  typedef struct packed {
    row_kind_t                 kind;
    logic [63:0]               val;
    logic [pms_pkg::LEN_W-1:0] len;
    logic                      eot;
    logic                      typed;
    masked_beat_t              want;
  } stim_row_t;

  localparam int N_ROWS = 30;
  localparam stim_row_t STIM_ROWS [N_ROWS] = '{
    // out of reset, length zero: bytes pass straight through
    '{ROW_TEXT, 64'h00, 4'd0, 1'b0, 1'b1, '{8'h00, 1'b0}},
    '{ROW_TEXT, 64'hFF, 4'd0, 1'b0, 1'b1, '{8'hFF, 1'b0}},
    '{ROW_TEXT, 64'h2A, 4'd0, 1'b1, 1'b1, '{8'h2A, 1'b1}},
    // "ab" with junk in the unused pattern bytes, short tail at the end
    '{ROW_CFG,  64'hFFFF_FFFF_FFFF_6261, 4'd2, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h61, 4'd0, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h61, 4'd0, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h62, 4'd0, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h61, 4'd0, 1'b1, 1'b0, '0},
    // zero bytes in pattern and text, no overlapping matches
    '{ROW_CFG,  64'h1234_5678_9A00_0000, 4'd3, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h00, 4'd0, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h00, 4'd0, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h00, 4'd0, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h00, 4'd0, 1'b1, 1'b0, '0},
    // over-long length acts as eight
    '{ROW_CFG,  64'h0807_0605_0403_0201, 4'd15, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h01, 4'd0, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h02, 4'd0, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h03, 4'd0, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h04, 4'd0, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h05, 4'd0, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h06, 4'd0, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h07, 4'd0, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h08, 4'd0, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h01, 4'd0, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h02, 4'd0, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h03, 4'd0, 1'b0, 1'b0, '0},
    // shorten the pattern while bytes are held, then end the stream
    '{ROW_CFG,  64'h0807_0605_0403_0201, 4'd1, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h01, 4'd0, 1'b1, 1'b0, '0},
    // pattern holding the mask byte itself
    '{ROW_CFG,  64'h0000_0000_0000_782A, 4'd2, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h2A, 4'd0, 1'b0, 1'b0, '0},
    '{ROW_TEXT, 64'h78, 4'd0, 1'b1, 1'b0, '0}
  };

  logic clk;
  logic rst;

  pms_in_if  text_in  ();
  pms_out_if text_out ();
  pms_cfg_if cfg_wr   ();

  pattern_mask_stream_filter u_dut (
    .clk      (clk),
    .rst      (rst),
    .data_in  (text_in),
    .data_out (text_out),
    .cfg      (cfg_wr)
  );

  // window model state and its copy of the registers
  logic [pms_pkg::BYTE_W-1:0] hold_win [pms_pkg::MAX_PATTERN];
  int unsigned                hold_cnt;
  logic [63:0]                pat_cfg;
  logic [pms_pkg::LEN_W-1:0]  len_cfg;
  masked_beat_t               step_beats [$];
  masked_beat_t               masked_q [$];

  int unsigned err_cnt = 0;
  int unsigned beat_cnt = 0;
  int unsigned cyc_cnt = 0;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        long_hold_req;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt == CYC_LIMIT) begin
      $display("%0t: timeout, %0d beats still expected", $time, masked_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int unsigned eff_len();
    return (len_cfg > pms_pkg::MAX_PATTERN) ? pms_pkg::MAX_PATTERN : int'(len_cfg);
  endfunction

  // mask the front span when the window starts with the pattern
  task automatic test_front(input int unsigned n);
    bit hit;
    if (n == 0 || hold_cnt < n) return;
    hit = 1'b1;
    for (int k = 0; k < n; k++)
      if (hold_win[k] != pat_cfg[8*k +: 8]) hit = 1'b0;
    if (hit)
      for (int k = 0; k < n; k++) hold_win[k] = pms_pkg::MASK_BYTE;
  endtask

  task automatic shift_out(input bit last);
    step_beats.push_back('{hold_win[0], last});
    for (int k = 0; k < pms_pkg::MAX_PATTERN - 1; k++) hold_win[k] = hold_win[k+1];
    hold_win[pms_pkg::MAX_PATTERN-1] = '0;
    hold_cnt--;
  endtask

  // one text beat into the window; leaves its output beats in step_beats
  task automatic mask_step(input logic [pms_pkg::BYTE_W-1:0] b, input bit eot);
    int unsigned n;
    int unsigned keep;
    n = eff_len();
    keep = (n > 0) ? n - 1 : 0;
    step_beats.delete();
    if (hold_cnt >= pms_pkg::MAX_PATTERN) hold_cnt = pms_pkg::MAX_PATTERN - 1;
    hold_win[hold_cnt] = b;
    hold_cnt++;
    while (hold_cnt > keep) begin
      test_front(n);
      shift_out(eot && hold_cnt == 1);
    end
    if (eot)
      while (hold_cnt > 0) begin
        test_front(n);
        shift_out(hold_cnt == 1);
      end
  endtask

  task automatic report(input string what, input logic [pms_pkg::BYTE_W-1:0] want,
                        input logic [pms_pkg::BYTE_W-1:0] got);
    err_cnt++;
    $display("%0t: %s mismatch, expected %02h actual %02h", $time, what, want, got);
  endtask

  // sender: random gaps, then hold the beat until it is taken
  task automatic send_beat(input logic [pms_pkg::BYTE_W-1:0] b, input bit eot,
                           input bit typed, input masked_beat_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      text_in.valid <= 1'b0;
      @(posedge clk);
    end
    text_in.valid       <= 1'b1;
    text_in.data_byte   <= b;
    text_in.end_of_text <= eot;
    do @(posedge clk); while (!text_in.ready);
    beat_cnt++;
    mask_step(b, eot);
    if (typed) masked_q.push_back(want);
    else foreach (step_beats[k]) masked_q.push_back(step_beats[k]);
  endtask

  task automatic wait_drain();
    while (masked_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // both registers, back to back, once the block has gone quiet
  task automatic reconfigure(input logic [63:0] pat, input logic [pms_pkg::LEN_W-1:0] n);
    text_in.valid <= 1'b0;
    wait_drain();
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= pms_pkg::REG_PATTERN_BYTES;
    cfg_wr.data  <= pat;
    do @(posedge clk); while (!cfg_wr.ready);
    pat_cfg = pat;
    cfg_wr.index <= pms_pkg::REG_PATTERN_LENGTH;
    cfg_wr.data  <= pms_pkg::CFG_DATA_W'(n);
    do @(posedge clk); while (!cfg_wr.ready);
    len_cfg = n;
    cfg_wr.valid <= 1'b0;
  endtask

  // bytes that tend to build or break matches
  function automatic logic [pms_pkg::BYTE_W-1:0] alphabet_byte();
    case ($urandom_range(5))
      0: return 8'h61;
      1: return 8'h62;
      2: return pms_pkg::MASK_BYTE;
      3: return 8'h00;
      4: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic random_setting();
    logic [63:0]               pat;
    logic [pms_pkg::LEN_W-1:0] n;
    int unsigned               r;
    pat = {$urandom, $urandom};
    r = $urandom_range(9);
    if (r == 0) n = '0;
    else if (r == 1) n = pms_pkg::LEN_W'($urandom_range(15, 9));
    else if (r == 2) n = pms_pkg::LEN_W'(pms_pkg::MAX_PATTERN);
    else n = pms_pkg::LEN_W'($urandom_range(pms_pkg::MAX_PATTERN, 1));
    for (int k = 0; k < pms_pkg::MAX_PATTERN; k++)
      if (k < n && $urandom_range(3) != 0) pat[8*k +: 8] = alphabet_byte();
    reconfigure(pat, n);
  endtask

  // text built mostly from whole or cut copies of the pattern
  task automatic send_stream(input int unsigned target, input bit close);
    logic [pms_pkg::BYTE_W-1:0] txt [$];
    int unsigned n;
    int unsigned cut;
    n = eff_len();
    if (n == 0) n = pms_pkg::MAX_PATTERN;
    while (txt.size() < target) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          cut = ($urandom_range(3) == 0) ? $urandom_range(n, 1) : n;
          for (int k = 0; k < cut; k++) txt.push_back(pat_cfg[8*k +: 8]);
        end
        4:       txt.push_back(pms_pkg::MASK_BYTE);
        5, 6:    txt.push_back(8'($urandom_range(255)));
        default: txt.push_back(alphabet_byte());
      endcase
    end
    foreach (txt[i]) send_beat(txt[i], close && (i == txt.size() - 1), 1'b0, '0);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin : rx_drive
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    text_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_done) begin
        hold_left = 60;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        text_out.ready <= 1'b0;
      end else begin
        text_out.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // output check against the oldest expected beat
  always @(posedge clk) begin : out_check
    masked_beat_t want;
    if (!rst && text_out.valid && text_out.ready) begin
      if (masked_q.size() == 0) begin
        report("unexpected beat, out_byte", 8'h00, text_out.out_byte);
      end else begin
        want = masked_q.pop_front();
        if (text_out.out_byte !== want.data) report("out_byte", want.data, text_out.out_byte);
        if (text_out.out_last !== want.last)
          report("out_last", 8'(want.last), 8'(text_out.out_last));
      end
    end
  end

  // stimulus
  initial begin : stim
    int unsigned phase_start;
    bit          split;
    rst                 = 1'b1;
    text_in.valid       = 1'b0;
    text_in.data_byte   = '0;
    text_in.end_of_text = 1'b0;
    cfg_wr.valid        = 1'b0;
    cfg_wr.index        = pms_pkg::REG_PATTERN_BYTES;
    cfg_wr.data         = '0;
    long_hold_req       = 1'b0;
    tx_idle_pct         = 38;
    rx_idle_pct         = 52;
    pat_cfg             = '0;
    len_cfg             = '0;
    hold_cnt            = 0;
    foreach (hold_win[k]) hold_win[k] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    for (int i = 0; i < N_ROWS; i++) begin
      if (STIM_ROWS[i].kind == ROW_CFG)
        reconfigure(STIM_ROWS[i].val, STIM_ROWS[i].len);
      else
        send_beat(STIM_ROWS[i].val[7:0], STIM_ROWS[i].eot, STIM_ROWS[i].typed,
                  STIM_ROWS[i].want);
    end

    // random streams in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 52 : 0;
      rx_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 38 : 0;
      random_setting();
      if (ph == 2) begin
        // receiver holds off while a long stream keeps coming
        long_hold_req <= 1'b1;
        send_stream(30, 1'b1);
      end
      phase_start = beat_cnt;
      while (beat_cnt - phase_start < PHASE_BEATS) begin
        split = ($urandom_range(5) == 0);
        send_stream($urandom_range(14, 1), !split);
        if (split || $urandom_range(2) == 0) random_setting();
      end
    end

    // close a stream left open by a mid-stream change
    if (hold_cnt != 0) send_beat(8'($urandom_range(255)), 1'b1, 1'b0, '0);
    text_in.valid <= 1'b0;
    wait_drain();

    if (masked_q.size() != 0)
      $display("%0t: %0d expected beats never arrived", $time, masked_q.size());
    if (err_cnt == 0 && masked_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pms_pkg.sv
rtl/core/pms_if.sv
rtl/core/pms_cell.sv
rtl/core/pattern_mask_stream_filter.sv
sim/tb_top.sv
